// ----- rtl/core/hard_sphere_insertion_check_macros.svh -----
// assertion helpers for the top-level core file
`ifndef HARD_SPHERE_INSERTION_CHECK_MACROS_SVH
`define HARD_SPHERE_INSERTION_CHECK_MACROS_SVH

// check on every rising clock edge outside reset
`define HSIC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check that also looks at the reset itself
`define HSIC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/core/hsic_pkg.sv -----
package hsic_pkg;

    // defaults for the top level parameters
    localparam int MAX_SPHERES_DEF = 128;
    localparam int COORD_W_DEF     = 16;

    // configuration port
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX    = 1'd1;
    localparam logic [CFG_W-1:0] RADIUS_RST = 16'd256;
    localparam logic [CFG_W-1:0] BOX_RST    = 16'd2560;

    // result word
    localparam int VERDICT_W   = 3;
    localparam int COUNT_W     = 8;
    localparam int OUT_TDATA_W = 16;
    localparam logic [VERDICT_W-1:0] V_ACCEPT  = 3'd0;
    localparam logic [VERDICT_W-1:0] V_OUTSIDE = 3'd1;
    localparam logic [VERDICT_W-1:0] V_OVERLAP = 3'd2;
    localparam logic [VERDICT_W-1:0] V_FULL    = 3'd3;
    localparam logic [VERDICT_W-1:0] V_CLEARED = 3'd4;

    // per-cell control from the sequencer
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

// ----- rtl/core/hsic_cell.sv -----
module hsic_cell #(
    parameter int COORD_WIDTH = hsic_pkg::COORD_W_DEF
) (
    input  logic                       i_clk,
    input  hsic_pkg::t_cell_ctl        i_ctl,
    input  logic [3*COORD_WIDTH-1:0]   i_next,
    input  logic [3*COORD_WIDTH-1:0]   i_cand,
    output logic [3*COORD_WIDTH-1:0]   o_data
);
    import hsic_pkg::*;

    logic [3*COORD_WIDTH-1:0] r_centre;

    // one stored centre: take a new candidate or pass along the ring
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_centre <= i_cand;
        end else if (i_ctl.shift) begin
            r_centre <= i_next;
        end
    end

    assign o_data = r_centre;

endmodule

// ----- rtl/core/hsic_dist.sv -----
module hsic_dist #(
    parameter int COORD_WIDTH = hsic_pkg::COORD_W_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [3*COORD_WIDTH-1:0]   i_cand,
    input  logic [3*COORD_WIDTH-1:0]   i_centre,
    input  logic [2*COORD_WIDTH+1:0]   i_thr,
    output logic                       o_valid,
    output logic                       o_close
);
    import hsic_pkg::*;

    localparam int SQ_W  = 2 * COORD_WIDTH;
    localparam int SUM_W = SQ_W + 2;

    logic [COORD_WIDTH-1:0] diff [3];
    logic [COORD_WIDTH-1:0] r_diff [3];
    logic [SQ_W-1:0]        r_sq [3];
    logic [SUM_W-1:0]       sum;
    logic                   r_v1;
    logic                   r_v2;
    logic                   r_v3;
    logic                   r_close;

    // absolute difference per axis
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            if (i_cand[a*COORD_WIDTH +: COORD_WIDTH] >= i_centre[a*COORD_WIDTH +: COORD_WIDTH]) begin
                diff[a] = i_cand[a*COORD_WIDTH +: COORD_WIDTH]
                        - i_centre[a*COORD_WIDTH +: COORD_WIDTH];
            end else begin
                diff[a] = i_centre[a*COORD_WIDTH +: COORD_WIDTH]
                        - i_cand[a*COORD_WIDTH +: COORD_WIDTH];
            end
        end
    end

    // sum of squares, exact width
    assign sum = {2'b00, r_sq[0]} + {2'b00, r_sq[1]} + {2'b00, r_sq[2]};

    // three stages: difference, square, sum and compare
    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r_diff[a] <= diff[a];
            r_sq[a]   <= r_diff[a] * r_diff[a];
        end
        r_close <= (sum < i_thr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_valid = r_v3;
    assign o_close = r_close;

endmodule

// ----- rtl/core/hard_sphere_insertion_check.sv -----
// channel  dir  handshake               payload
// s        in   i_s_tvalid/o_s_tready   tdata cand_x,cand_y,cand_z; tuser action
// m        out  o_m_tvalid/i_m_tready   tdata verdict,stored_count
// cfg      in   i_cfg_we                i_cfg_idx, i_cfg_data
// a clear or an out-of-box candidate is answered in the cycle after it is taken
// a candidate inside the box is checked against the whole store: the ring of cells
//   turns once, one stored centre a cycle past the distance unit, whose three
//   stages drain before the verdict is written
// one word at a time; a new word is taken when no scan runs and the result register is free
// i_rst_n is synchronous; it empties the store and restores the default radius and box
// the result register holds its word while i_m_tready is low
module hard_sphere_insertion_check #(
    parameter int MAX_SPHERES = hsic_pkg::MAX_SPHERES_DEF,
    parameter int COORD_WIDTH = hsic_pkg::COORD_W_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // cfg
    input  logic                                   i_cfg_we,
    input  logic [hsic_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [hsic_pkg::CFG_W-1:0]             i_cfg_data,
    // candidate stream
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    // tdata: cand_x, cand_y, cand_z, zero pad
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]     i_s_tdata,
    // tuser: action
    input  logic                                   i_s_tuser,
    // result stream
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    // tdata: verdict, stored_count, zero pad
    output logic [hsic_pkg::OUT_TDATA_W-1:0]       o_m_tdata
);
    import hsic_pkg::*;

    localparam int CNT_W = $clog2(MAX_SPHERES + 3);
    localparam int IDX_W = $clog2(MAX_SPHERES);
    localparam int ENT_W = 3 * COORD_WIDTH;
    localparam int THR_W = 2 * COORD_WIDTH + 2;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic                   r_state, n_state;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [CNT_W-1:0]       r_held, n_held;
    logic                   r_hit, n_hit;
    logic                   r_out_valid, n_out_valid;
    logic [VERDICT_W-1:0]   r_verdict, n_verdict;
    logic [CNT_W-1:0]       r_out_count, n_out_count;
    logic [COORD_WIDTH-1:0] r_radius;
    logic [COORD_WIDTH-1:0] r_box;
    logic [THR_W-1:0]       r_thr;
    logic [ENT_W-1:0]       r_cand;

    logic [COORD_WIDTH+CFG_W-1:0] cfg_ext;
    logic [COORD_WIDTH+CFG_W-1:0] radius_rst_ext;
    logic [COORD_WIDTH+CFG_W-1:0] box_rst_ext;
    logic [CNT_W+COUNT_W-1:0]     count_ext;
    logic [2*COORD_WIDTH-1:0]     rad_sq;
    logic [ENT_W-1:0]             cand_in;
    logic [2:0]                   axis_in;
    logic                         s_acc;
    logic                         issue;
    logic                         finish;
    logic                         hit_final;
    logic                         load_en;
    logic                         d_valid;
    logic                         d_close;
    logic [ENT_W-1:0]             ring [MAX_SPHERES];
    t_cell_ctl                    cell_ctl [MAX_SPHERES];

    // register values fitted to the coordinate width
    assign cfg_ext        = {{COORD_WIDTH{1'b0}}, i_cfg_data};
    assign radius_rst_ext = {{COORD_WIDTH{1'b0}}, RADIUS_RST};
    assign box_rst_ext    = {{COORD_WIDTH{1'b0}}, BOX_RST};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= radius_rst_ext[COORD_WIDTH-1:0];
            r_box    <= box_rst_ext[COORD_WIDTH-1:0];
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_RADIUS: r_radius <= cfg_ext[COORD_WIDTH-1:0];
                REG_BOX:    r_box    <= cfg_ext[COORD_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // overlap threshold (2r)^2 = 4 r^2
    assign rad_sq = r_radius * r_radius;

    always_ff @(posedge i_clk) begin
        r_thr <= {rad_sq, 2'b00};
    end

    // box test per axis, r <= c and c + r <= L without wrap
    assign cand_in = i_s_tdata[ENT_W-1:0];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            axis_in[a] = (cand_in[a*COORD_WIDTH +: COORD_WIDTH] >= r_radius)
                && (({1'b0, cand_in[a*COORD_WIDTH +: COORD_WIDTH]} + {1'b0, r_radius})
                    <= {1'b0, r_box});
        end
    end

    assign o_s_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_tready);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign issue      = (r_state == S_RUN) && (r_cnt < CNT_W'(MAX_SPHERES));
    assign finish     = (r_state == S_RUN) && (r_cnt == CNT_W'(MAX_SPHERES + 2));
    assign hit_final  = r_hit || (d_valid && d_close);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_held      = r_held;
        n_hit       = r_hit;
        n_out_valid = r_out_valid && !i_m_tready;
        n_verdict   = r_verdict;
        n_out_count = r_out_count;
        load_en     = 1'b0;
        if (s_acc) begin
            if (i_s_tuser) begin
                n_held      = '0;
                n_out_valid = 1'b1;
                n_verdict   = V_CLEARED;
                n_out_count = '0;
            end else if (!(&axis_in)) begin
                n_out_valid = 1'b1;
                n_verdict   = V_OUTSIDE;
                n_out_count = r_held;
            end else begin
                n_state = S_RUN;
                n_cnt   = '0;
                n_hit   = 1'b0;
            end
        end
        if (r_state == S_RUN) begin
            n_cnt = r_cnt + 1'b1;
            if (d_valid && d_close) begin
                n_hit = 1'b1;
            end
            if (finish) begin
                n_state     = S_IDLE;
                n_out_valid = 1'b1;
                n_out_count = r_held;
                if (hit_final) begin
                    n_verdict = V_OVERLAP;
                end else if (r_held >= CNT_W'(MAX_SPHERES)) begin
                    n_verdict = V_FULL;
                end else begin
                    n_verdict   = V_ACCEPT;
                    n_held      = r_held + 1'b1;
                    n_out_count = r_held + 1'b1;
                    load_en     = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_held      <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_held      <= n_held;
            r_hit       <= n_hit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_verdict   <= n_verdict;
        r_out_count <= n_out_count;
        if (s_acc) begin
            r_cand <= cand_in;
        end
    end

    // ring of cells, cell 0 faces the distance unit
    for (genvar i = 0; i < MAX_SPHERES; i++) begin : g_cell
        assign cell_ctl[i] = '{shift: issue,
                               load: load_en && (r_held[IDX_W-1:0] == IDX_W'(i))};

        hsic_cell #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_cell (
            .i_clk  (i_clk),
            .i_ctl  (cell_ctl[i]),
            .i_next (ring[(i + 1) % MAX_SPHERES]),
            .i_cand (r_cand),
            .o_data (ring[i])
        );
    end

    // distance test against the centre in cell 0
    hsic_dist #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (issue && (r_cnt < r_held)),
        .i_cand   (r_cand),
        .i_centre (ring[0]),
        .i_thr    (r_thr),
        .o_valid  (d_valid),
        .o_close  (d_close)
    );

    // result word
    assign count_ext  = {{COUNT_W{1'b0}}, r_out_count};
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_TDATA_W - VERDICT_W - COUNT_W){1'b0}},
                         count_ext[COUNT_W-1:0], r_verdict};

    `include "hard_sphere_insertion_check_macros.svh"

    `HSIC_ASSERT_RST(a_reset_empty, !i_rst_n |=> (r_held == '0 && r_state == S_IDLE && !r_out_valid), "reset did not empty the store")
    `HSIC_ASSERT(a_run_out_free, (r_state == S_RUN) |-> !r_out_valid, "result register busy during a scan")
    `HSIC_ASSERT(a_held_bound, r_held <= CNT_W'(MAX_SPHERES), "stored count beyond capacity")
    `HSIC_ASSERT(a_clear_result, (s_acc && i_s_tuser) |=> (r_held == '0 && r_verdict == V_CLEARED), "clear not applied")
    `HSIC_ASSERT(a_append_count, (finish && !hit_final && r_held < CNT_W'(MAX_SPHERES)) |=> (r_held == $past(r_held) + 1'b1), "accepted centre not appended")

endmodule

// ----- tb/sv/tb_hard_sphere_insertion_check.sv -----
module tb_hard_sphere_insertion_check;
    import hsic_pkg::*;

    localparam int SPHERES     = MAX_SPHERES_DEF;
    localparam int CW          = COORD_W_DEF;
    localparam int IN_W        = ((3*CW+7)/8)*8;
    localparam int COORD_MAX   = (1 << CW) - 1;
    localparam int CYCLE_LIMIT = 1_000_000;

    // one expected result word
    typedef struct packed {
        logic [VERDICT_W-1:0] verdict;
        logic [COUNT_W-1:0]   count;
    } t_verdict_word;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [IN_W-1:0]      i_s_tdata;
    logic                 i_s_tuser;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    // shadow of the block: stored centres, count and geometry
    bit [CW-1:0]    held_pos[SPHERES][3];
    int             held_n;
    bit [CFG_W-1:0] radius_q;
    bit [CFG_W-1:0] box_q;

    t_verdict_word verdict_queue[$];

    bit calm;
    int stall_left;
    int fail_count;
    int cycles;
    int offers;
    int clears;
    int settings;
    int verdict_tally[5];

    hard_sphere_insertion_check u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_hard_sphere_insertion_check: done, errors");
            $finish;
        end
    end

    // result side stalls in random bursts unless calm
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 4);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // compare each result word with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_verdict_word want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (verdict_queue.size() == 0) begin
                $error("result word 0x%0h with no prediction pending", o_m_tdata);
                fail_count++;
            end else begin
                want = verdict_queue.pop_front();
                if (want.verdict <= V_CLEARED)
                    verdict_tally[want.verdict]++;
                if (o_m_tdata[VERDICT_W-1:0] !== want.verdict) begin
                    $error("verdict: expected %0d, got %0d",
                           want.verdict, o_m_tdata[VERDICT_W-1:0]);
                    fail_count++;
                end
                if (o_m_tdata[VERDICT_W +: COUNT_W] !== want.count) begin
                    $error("stored_count: expected %0d, got %0d",
                           want.count, o_m_tdata[VERDICT_W +: COUNT_W]);
                    fail_count++;
                end
            end
        end
    end

    function automatic bit axis_fits(bit [CW-1:0] c);
        return c >= radius_q && ({1'b0, c} + {1'b0, radius_q}) <= {1'b0, box_q};
    endfunction

    // judge one word against the shadow store and update it
    function automatic t_verdict_word judge_candidate(bit act, bit [CW-1:0] x,
                                                      bit [CW-1:0] y, bit [CW-1:0] z);
        t_verdict_word w;
        longint dx, dy, dz, thr;
        w.verdict = V_ACCEPT;
        if (act) begin
            held_n = 0;
            w.verdict = V_CLEARED;
        end else if (!(axis_fits(x) && axis_fits(y) && axis_fits(z))) begin
            w.verdict = V_OUTSIDE;
        end else begin
            thr = longint'(radius_q) * longint'(radius_q) * 4;
            for (int k = 0; k < held_n && w.verdict == V_ACCEPT; k++) begin
                dx = longint'(x) - longint'(held_pos[k][0]);
                dy = longint'(y) - longint'(held_pos[k][1]);
                dz = longint'(z) - longint'(held_pos[k][2]);
                if (dx*dx + dy*dy + dz*dz < thr)
                    w.verdict = V_OVERLAP;
            end
            if (w.verdict == V_ACCEPT) begin
                if (held_n >= SPHERES) begin
                    w.verdict = V_FULL;
                end else begin
                    held_pos[held_n][0] = x;
                    held_pos[held_n][1] = y;
                    held_pos[held_n][2] = z;
                    held_n++;
                end
            end
        end
        w.count = held_n[COUNT_W-1:0];
        return w;
    endfunction

    // random coordinate inside [radius, box - radius] where that range exists
    function automatic bit [CW-1:0] fitted_axis();
        if (int'(box_q) >= 2*int'(radius_q))
            return CW'($urandom_range(int'(radius_q), int'(box_q) - int'(radius_q)));
        return CW'($urandom_range(0, COORD_MAX));
    endfunction

    // send one word, optionally after an idle burst; valid stays high afterwards
    task automatic offer_word(input bit act, input bit [CW-1:0] x,
                              input bit [CW-1:0] y, input bit [CW-1:0] z);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= IN_W'({z, y, x});
        i_s_tuser  <= act;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        verdict_queue.push_back(judge_candidate(act, x, y, z));
        if (act)
            clears++;
        else
            offers++;
    endtask

    // stop sending and wait for every predicted word
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (verdict_queue.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // write both registers while the block is idle
    task automatic set_geometry(input bit [CFG_W-1:0] radius, input bit [CFG_W-1:0] box);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_RADIUS;
        i_cfg_data <= radius;
        @(posedge i_clk);
        radius_q = radius;
        i_cfg_idx  <= REG_BOX;
        i_cfg_data <= box;
        @(posedge i_clk);
        box_q = box;
        i_cfg_we <= 1'b0;
        settings++;
    endtask

    // reset geometry: bounds, exact contact distance, clear
    task automatic test_default_geometry();
        offer_word(1'b1, 16'h1234, 16'hABCD, 16'h5A5A);
        offer_word(1'b0, 16'd0, 16'd0, 16'd0);
        offer_word(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        offer_word(1'b0, 16'd255, 16'd1280, 16'd1280);
        offer_word(1'b0, 16'd1280, 16'd2305, 16'd1280);
        offer_word(1'b0, 16'd256, 16'd256, 16'd256);
        offer_word(1'b0, 16'd2304, 16'd2304, 16'd2304);
        offer_word(1'b0, 16'd1280, 16'd1280, 16'd1280);
        offer_word(1'b0, 16'd1280, 16'd1280, 16'd1280);
        // exactly two radii apart is not an overlap
        offer_word(1'b0, 16'd1792, 16'd1280, 16'd1280);
        offer_word(1'b0, 16'd1280, 16'd1280, 16'd769);
        // outside and overlapping at once reports outside
        offer_word(1'b0, 16'd255, 16'd256, 16'd256);
        offer_word(1'b1, 16'hFFFF, 16'h0000, 16'hFFFF);
        offer_word(1'b0, 16'd1280, 16'd1280, 16'd1280);
    endtask

    // zero and full-scale registers, box shorter than a diameter
    task automatic test_register_extremes();
        set_geometry(16'd0, 16'hFFFF);
        offer_word(1'b1, 16'd0, 16'd0, 16'd0);
        offer_word(1'b0, 16'd0, 16'd0, 16'd0);
        offer_word(1'b0, 16'd0, 16'd0, 16'd0);
        offer_word(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        set_geometry(16'hFFFF, 16'hFFFF);
        offer_word(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        offer_word(1'b0, 16'd0, 16'd0, 16'd0);
        set_geometry(16'd1000, 16'd1500);
        offer_word(1'b0, 16'd1000, 16'd1000, 16'd1000);
        offer_word(1'b0, 16'd1250, 16'd1250, 16'd1250);
        set_geometry(16'd0, 16'd0);
        offer_word(1'b0, 16'd0, 16'd0, 16'd0);
        offer_word(1'b0, 16'd1, 16'd0, 16'd0);
        // huge threshold: near-full-scale radius, only the box centre fits
        set_geometry(16'd32767, 16'hFFFF);
        offer_word(1'b1, 16'd0, 16'd0, 16'd0);
        offer_word(1'b0, 16'd32767, 16'd32768, 16'd32767);
        offer_word(1'b0, 16'd32768, 16'd32768, 16'd32768);
        offer_word(1'b0, 16'd32768, 16'd32767, 16'd32768);
    endtask

    // fill every slot, then overlap and outside both beat full
    task automatic test_store_full();
        set_geometry(16'd1, 16'hFFFF);
        offer_word(1'b1, 16'd0, 16'd0, 16'd0);
        for (int k = 0; k < SPHERES; k++)
            offer_word(1'b0, CW'(100 + 4*k), 16'd100, 16'd100);
        offer_word(1'b0, 16'd100, 16'd100, 16'd100);
        offer_word(1'b0, 16'd10000, 16'd10000, 16'd10000);
        offer_word(1'b0, 16'd0, 16'd0, 16'd0);
        offer_word(1'b1, 16'd7, 16'd7, 16'd7);
        offer_word(1'b0, 16'd200, 16'd200, 16'd200);
    endtask

    // one random word: mostly in-box or near a stored centre, some noise
    task automatic random_word(input int clear_pct);
        int pick;
        int k;
        int c;
        int delta;
        bit [CW-1:0] v[3];
        pick = $urandom_range(0, 99);
        k = (held_n > 0) ? $urandom_range(0, held_n - 1) : 0;
        for (int a = 0; a < 3; a++) begin
            if (pick < 20) begin
                v[a] = CW'($urandom_range(0, COORD_MAX));
            end else if (pick < 32) begin
                case ($urandom_range(0, 4))
                    0: c = int'(radius_q) - 1;
                    1: c = int'(radius_q);
                    2: c = int'(box_q) - int'(radius_q);
                    3: c = int'(box_q) - int'(radius_q) + 1;
                    default: c = int'(fitted_axis());
                endcase
                v[a] = c[CW-1:0];
            end else if (pick < 55 && held_n > 0) begin
                delta = $urandom_range(0, 2*int'(radius_q) + 2);
                c = $urandom_range(0, 1) ? int'(held_pos[k][a]) + delta
                                         : int'(held_pos[k][a]) - delta;
                v[a] = c[CW-1:0];
            end else begin
                v[a] = fitted_axis();
            end
        end
        offer_word(pick < clear_pct, v[0], v[1], v[2]);
    endtask

    // several geometries, the last one without idling
    task automatic test_random_geometries();
        int rr;
        int bb;
        int n;
        int clear_pct;
        for (int p = 0; p < 6; p++) begin
            n = 60;
            clear_pct = 4;
            case (p)
                0: begin rr = RADIUS_RST; bb = BOX_RST; n = 60; end
                1: begin rr = 64; bb = 4096; end
                2: begin rr = $urandom_range(1, 512); bb = $urandom_range(2*rr, 8000); end
                // zero radius without clears runs the store full
                3: begin rr = 0; bb = $urandom_range(0, COORD_MAX); n = 200; clear_pct = 0; end
                4: begin
                    rr = $urandom_range(0, COORD_MAX);
                    bb = $urandom_range(0, COORD_MAX);
                    n = 50;
                end
                default: begin
                    rr = $urandom_range(16, 300);
                    bb = $urandom_range(4*rr, COORD_MAX);
                    n = 100;
                end
            endcase
            set_geometry(CFG_W'(rr), CFG_W'(bb));
            if (p == 5)
                calm = 1'b1;
            repeat (n) random_word(clear_pct);
        end
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= REG_RADIUS;
        i_cfg_data <= '0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= 1'b0;
        i_m_tready <= 1'b0;
        held_n   = 0;
        radius_q = RADIUS_RST;
        box_q    = BOX_RST;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_default_geometry();
        test_register_extremes();
        test_store_full();
        test_random_geometries();

        // let any stray word show up
        drain();
        repeat (SPHERES + 16) @(posedge i_clk);
        if (verdict_queue.size() != 0) begin
            $error("%0d predicted words never arrived", verdict_queue.size());
            fail_count++;
        end

        $display("run covered %0d candidates and %0d clears over %0d register settings",
                 offers, clears, settings);
        $display("verdicts: accepted %0d, outside %0d, overlap %0d, full %0d, cleared %0d",
                 verdict_tally[0], verdict_tally[1], verdict_tally[2],
                 verdict_tally[3], verdict_tally[4]);
        if (fail_count == 0)
            $display("tb_hard_sphere_insertion_check: done, clean");
        else
            $display("tb_hard_sphere_insertion_check: done, errors");
        $finish;
    end

endmodule
